// File: hdl/mbe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types, codes and constants of the escape-time engine
// ----------------------------------------------------------------------------
package mbe_pkg;

    // fixed field widths
    localparam int COL_W       = 12;
    localparam int ROW_W       = 12;
    localparam int COUNT_OUT_W = 16;
    localparam int INDEX_W     = 24;
    localparam int LIMIT_W     = 16;
    localparam int THR_W       = 4;
    localparam int TILE_W_W    = 13;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 40;

    // parameter defaults
    localparam int COORD_BITS_DEF   = 64;
    localparam int MAX_TILE_DIM_DEF = 4096;
    localparam int COUNT_BITS_DEF   = 16;

    // register reset values
    localparam logic [LIMIT_W-1:0]  ITER_LIMIT_RST = 16'd256;
    localparam logic [THR_W-1:0]    ESC_THR_RST    = 4'd4;
    localparam logic [TILE_W_W-1:0] TILE_WIDTH_RST = 13'd4096;

    // partial product issue counts
    localparam int PART_CNT_W = 4;
    localparam int C_ISSUES   = 8;
    localparam int Z_ISSUES   = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_REAL = 3'd0,
        REG_ORIGIN_IMAG = 3'd1,
        REG_STEP_REAL   = 3'd2,
        REG_STEP_IMAG   = 3'd3,
        REG_ITER_LIMIT  = 3'd4,
        REG_ESC_THR     = 3'd5,
        REG_TILE_WIDTH  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PK_SQR,
        PK_SQI,
        PK_ZZ,
        PK_CR,
        PK_CI
    } prod_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_MUL,
        ST_C_DRAIN,
        ST_C_NEG,
        ST_C_ADD,
        ST_Z_MUL,
        ST_Z_DRAIN,
        ST_CHECK,
        ST_ROUND,
        ST_UPD_R,
        ST_UPD_I,
        ST_UPD_MAG,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       load_item;
        logic       acc_clr;
        logic       mul_issue;
        prod_kind_t mul_kind;
        logic [1:0] mul_part;
        logic       c_neg;
        logic       c_add;
        logic       check_prep;
        logic       count_inc;
        logic       round_step;
        logic       upd_r;
        logic       upd_i;
        logic       upd_mag;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic escape;
        logic at_limit;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/mbe_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_cfg
// configuration register file, one write per beat
// ----------------------------------------------------------------------------
module mbe_cfg
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    output logic signed [COORD_BITS-1:0]      origin_real,
    output logic signed [COORD_BITS-1:0]      origin_imag,
    output logic signed [COORD_BITS-1:0]      step_real,
    output logic signed [COORD_BITS-1:0]      step_imag,
    output logic [LIMIT_W-1:0]                iter_limit,
    output logic [THR_W-1:0]                  esc_thr,
    output logic [TILE_W_W-1:0]               tile_width
);

    logic signed [COORD_BITS-1:0] origin_real_reg;
    logic signed [COORD_BITS-1:0] origin_imag_reg;
    logic signed [COORD_BITS-1:0] step_real_reg;
    logic signed [COORD_BITS-1:0] step_imag_reg;
    logic [LIMIT_W-1:0]           iter_limit_reg;
    logic [THR_W-1:0]             esc_thr_reg;
    logic [TILE_W_W-1:0]          tile_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_real_reg <= '0;
            origin_imag_reg <= '0;
            step_real_reg   <= '0;
            step_imag_reg   <= '0;
            iter_limit_reg  <= ITER_LIMIT_RST;
            esc_thr_reg     <= ESC_THR_RST;
            tile_width_reg  <= TILE_WIDTH_RST;
        end
        else if (cfg_valid)
        begin
            // unknown index: write dropped
            case (cfg_index)
                REG_ORIGIN_REAL: origin_real_reg <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_IMAG: origin_imag_reg <= cfg_data[COORD_BITS-1:0];
                REG_STEP_REAL:   step_real_reg   <= cfg_data[COORD_BITS-1:0];
                REG_STEP_IMAG:   step_imag_reg   <= cfg_data[COORD_BITS-1:0];
                REG_ITER_LIMIT:  iter_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_ESC_THR:     esc_thr_reg     <= cfg_data[THR_W-1:0];
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data[TILE_W_W-1:0];
                default:         ;
            endcase
        end
    end

    assign origin_real = origin_real_reg;
    assign origin_imag = origin_imag_reg;
    assign step_real   = step_real_reg;
    assign step_imag   = step_imag_reg;
    assign iter_limit  = iter_limit_reg;
    assign esc_thr     = esc_thr_reg;
    assign tile_width  = tile_width_reg;

endmodule
`default_nettype wire

// File: hdl/mbe_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_dp
// datapath: shared half-width multiplier, accumulators, rounding and z update
// ----------------------------------------------------------------------------
module mbe_dp
    import mbe_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int MAX_TILE_DIM = MAX_TILE_DIM_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dp_cmd_t                       cmd,
    output dp_stat_t                           stat,
    input  wire logic [COL_W-1:0]              s_col,
    input  wire logic [ROW_W-1:0]              s_row,
    input  wire logic signed [COORD_BITS-1:0]  origin_real,
    input  wire logic signed [COORD_BITS-1:0]  origin_imag,
    input  wire logic signed [COORD_BITS-1:0]  step_real,
    input  wire logic signed [COORD_BITS-1:0]  step_imag,
    input  wire logic [LIMIT_W-1:0]            iter_limit,
    input  wire logic [THR_W-1:0]              esc_thr,
    input  wire logic [TILE_W_W-1:0]           tile_width,
    output logic [COUNT_OUT_W-1:0]             out_count,
    output logic [INDEX_W-1:0]                 out_index
);

    localparam int W     = COORD_BITS;
    localparam int H     = (COORD_BITS + 1) / 2;
    localparam int ACC_W = 4 * H + 2;
    localparam int F     = COORD_BITS - 4;
    localparam int CMP_W = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;

    localparam logic [ACC_W-1:0] ONE_ACC = ACC_W'(1);
    localparam logic [ACC_W-1:0] HALF_R  = ONE_ACC << (F - 1);
    localparam logic [ACC_W-1:0] HALF_I  = ONE_ACC << (F - 2);

    function automatic logic signed [W-1:0] sat_w(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-W:0]    hi;
        logic                fits;
        logic signed [W-1:0] r;
        hi   = v[ACC_W-1:W-1];
        fits = (&hi) | ~(|hi);
        if (fits)
            r = v[W-1:0];
        else if (v[ACC_W-1])
            r = {1'b1, {(W-1){1'b0}}};
        else
            r = {1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] x);
        logic [W-1:0] r;
        r = x[W-1] ? W'(-x) : W'(x);
        return r;
    endfunction

    // item and iteration state
    logic [COL_W-1:0]          col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [W-1:0]              sr_mag_reg;
    logic [W-1:0]              si_mag_reg;
    logic signed [W-1:0]       cr_reg;
    logic signed [W-1:0]       ci_reg;
    logic signed [W-1:0]       zr_reg;
    logic signed [W-1:0]       zi_reg;
    logic [W-1:0]              zr_mag_reg;
    logic [W-1:0]              zi_mag_reg;
    logic signed [W-1:0]       nr_reg;
    logic signed [W-1:0]       ni_reg;
    logic [COUNT_BITS-1:0]     count_reg;
    logic [ROW_W+TILE_W_W-1:0] idx_prod_reg;
    logic [COUNT_OUT_W-1:0]    out_count_reg;
    logic [INDEX_W-1:0]        out_index_reg;

    // multiplier pipe
    logic [2*H-1:0]            pp_reg;
    logic [1:0]                pp_shift_reg;
    prod_kind_t                pp_kind_reg;
    logic                      pp_vld_reg;

    logic signed [ACC_W-1:0]   acc_sum_reg;
    logic signed [ACC_W-1:0]   acc_diff_reg;
    logic signed [ACC_W-1:0]   acc_prod_reg;

    logic [W-1:0]              a_op;
    logic [W-1:0]              b_op;
    logic [2*H-1:0]            a_ext;
    logic [2*H-1:0]            b_ext;
    logic [H-1:0]              a_half;
    logic [H-1:0]              b_half;
    logic [ACC_W-1:0]          pp_ext;
    logic signed [ACC_W-1:0]   pp_shifted;
    logic [ACC_W-1:0]          thr;
    logic [COUNT_BITS:0]       count_inc;
    logic [TILE_W_W-1:0]       width_eff;

    // operand select
    always_comb
    begin
        unique case (cmd.mul_kind)
            PK_SQR:
            begin
                a_op = zr_mag_reg;
                b_op = zr_mag_reg;
            end
            PK_SQI:
            begin
                a_op = zi_mag_reg;
                b_op = zi_mag_reg;
            end
            PK_ZZ:
            begin
                a_op = zr_mag_reg;
                b_op = zi_mag_reg;
            end
            PK_CR:
            begin
                a_op = sr_mag_reg;
                b_op = W'(col_reg);
            end
            PK_CI:
            begin
                a_op = si_mag_reg;
                b_op = W'(row_reg);
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign a_ext  = (2 * H)'(a_op);
    assign b_ext  = (2 * H)'(b_op);
    assign a_half = cmd.mul_part[0] ? a_ext[2*H-1:H] : a_ext[H-1:0];
    assign b_half = cmd.mul_part[1] ? b_ext[2*H-1:H] : b_ext[H-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
        begin
            pp_reg       <= a_half * b_half;
            pp_shift_reg <= 2'(cmd.mul_part[0]) + 2'(cmd.mul_part[1]);
            pp_kind_reg  <= cmd.mul_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pp_vld_reg <= 1'b0;
        else
            pp_vld_reg <= cmd.mul_issue;
    end

    assign pp_ext = ACC_W'(pp_reg);

    always_comb
    begin
        unique case (pp_shift_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext << H;
            2'd2:    pp_shifted = pp_ext << (2 * H);
            default: pp_shifted = '0;
        endcase
    end

    // accumulators
    always_ff @(posedge clk)
    begin
        priority if (cmd.load_item || cmd.acc_clr)
        begin
            acc_sum_reg  <= '0;
            acc_diff_reg <= '0;
            acc_prod_reg <= '0;
        end
        else if (cmd.c_neg)
        begin
            acc_sum_reg  <= step_real[W-1] ? -acc_sum_reg : acc_sum_reg;
            acc_diff_reg <= step_imag[W-1] ? -acc_diff_reg : acc_diff_reg;
        end
        else if (cmd.check_prep)
        begin
            acc_diff_reg <= acc_diff_reg + $signed(HALF_R);
            acc_prod_reg <= (zr_reg[W-1] ^ zi_reg[W-1]) ? -acc_prod_reg : acc_prod_reg;
        end
        else if (cmd.round_step)
        begin
            acc_prod_reg <= acc_prod_reg + $signed(HALF_I);
        end
        else if (pp_vld_reg)
        begin
            unique case (pp_kind_reg)
                PK_SQR:
                begin
                    acc_sum_reg  <= acc_sum_reg + pp_shifted;
                    acc_diff_reg <= acc_diff_reg + pp_shifted;
                end
                PK_SQI:
                begin
                    acc_sum_reg  <= acc_sum_reg + pp_shifted;
                    acc_diff_reg <= acc_diff_reg - pp_shifted;
                end
                PK_ZZ:   acc_prod_reg <= acc_prod_reg + pp_shifted;
                PK_CR:   acc_sum_reg  <= acc_sum_reg + pp_shifted;
                PK_CI:   acc_diff_reg <= acc_diff_reg + pp_shifted;
                default: ;
            endcase
        end
        else
        begin
            // nothing to accumulate, hold
        end
    end

    // c, z and intermediate rounding
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            col_reg    <= s_col;
            row_reg    <= s_row;
            sr_mag_reg <= mag_w(step_real);
            si_mag_reg <= mag_w(step_imag);
            zr_reg     <= '0;
            zi_reg     <= '0;
            zr_mag_reg <= '0;
            zi_mag_reg <= '0;
        end
        if (cmd.c_add)
        begin
            cr_reg <= sat_w(ACC_W'(origin_real) + acc_sum_reg);
            ci_reg <= sat_w(ACC_W'(origin_imag) + acc_diff_reg);
        end
        if (cmd.round_step)
            nr_reg <= sat_w(acc_diff_reg >>> F);
        if (cmd.upd_r)
        begin
            zr_reg <= sat_w(ACC_W'(nr_reg) + ACC_W'(cr_reg));
            ni_reg <= sat_w(acc_prod_reg >>> (F - 1));
        end
        if (cmd.upd_i)
        begin
            zi_reg     <= sat_w(ACC_W'(ni_reg) + ACC_W'(ci_reg));
            zr_mag_reg <= mag_w(zr_reg);
        end
        if (cmd.upd_mag)
            zi_mag_reg <= mag_w(zi_reg);
    end

    // iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.load_item)
            count_reg <= '0;
        else if (cmd.count_inc)
            count_reg <= count_inc[COUNT_BITS-1:0];
    end

    assign count_inc = (COUNT_BITS + 1)'(count_reg) + (COUNT_BITS + 1)'(1);
    assign thr       = ACC_W'(esc_thr) << (2 * F);

    assign stat.escape   = $unsigned(acc_sum_reg) >= thr;
    assign stat.at_limit = (CMP_W'(count_inc) >= CMP_W'(iter_limit))
                         || (count_inc == {1'b0, {COUNT_BITS{1'b1}}});

    // pixel index
    assign width_eff = (32'(tile_width) > 32'(MAX_TILE_DIM)) ? TILE_W_W'(MAX_TILE_DIM)
                                                             : tile_width;

    always_ff @(posedge clk)
    begin
        idx_prod_reg <= (ROW_W + TILE_W_W)'(row_reg) * (ROW_W + TILE_W_W)'(width_eff);
        if (cmd.out_load)
        begin
            out_count_reg <= COUNT_OUT_W'(count_reg);
            out_index_reg <= idx_prod_reg[INDEX_W-1:0] + INDEX_W'(col_reg);
        end
    end

    assign out_count = out_count_reg;
    assign out_index = out_index_reg;

`ifndef SYNTH
    a_sum_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check_prep |-> !acc_sum_reg[ACC_W-1])
        else $error("squared magnitude went negative");

    a_count_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> (count_reg != {COUNT_BITS{1'b1}}))
        else $error("iteration count would wrap");

    a_mag_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_mag |-> (zr_mag_reg == mag_w(zr_reg)))
        else $error("real magnitude out of step with zr");

    a_pp_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.c_neg || cmd.check_prep) |-> !pp_vld_reg)
        else $error("partial product still in flight at accumulator fixup");
`endif

endmodule
`default_nettype wire

// File: hdl/mbe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_ctrl
// controller: sequences partial products, escape test and z update per item
// ----------------------------------------------------------------------------
module mbe_ctrl
    import mbe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    state_t                state_reg;
    state_t                state_next;
    logic [PART_CNT_W-1:0] part_cnt_reg;
    logic [PART_CNT_W-1:0] part_cnt_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic                  c_last;
    logic                  z_last;
    logic                  out_free;

    assign c_last   = part_cnt_reg == PART_CNT_W'(C_ISSUES - 1);
    assign z_last   = part_cnt_reg == PART_CNT_W'(Z_ISSUES - 1);
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_C_MUL;
            ST_C_MUL:   if (c_last) state_next = ST_C_DRAIN;
            ST_C_DRAIN: state_next = ST_C_NEG;
            ST_C_NEG:   state_next = ST_C_ADD;
            ST_C_ADD:   state_next = ST_Z_MUL;
            ST_Z_MUL:   if (z_last) state_next = ST_Z_DRAIN;
            ST_Z_DRAIN: state_next = ST_CHECK;
            ST_CHECK:
            begin
                priority if (stat.escape)
                    state_next = ST_FINISH;
                else if (stat.at_limit)
                    state_next = ST_FINISH;
                else
                    state_next = ST_ROUND;
            end
            ST_ROUND:   state_next = ST_UPD_R;
            ST_UPD_R:   state_next = ST_UPD_I;
            ST_UPD_I:   state_next = ST_UPD_MAG;
            ST_UPD_MAG: state_next = ST_Z_MUL;
            ST_FINISH:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // issue counter
    always_comb
    begin
        if ((state_reg == ST_C_MUL && !c_last) || (state_reg == ST_Z_MUL && !z_last))
            part_cnt_next = part_cnt_reg + PART_CNT_W'(1);
        else
            part_cnt_next = '0;
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.mul_kind  = PK_SQR;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_C_MUL:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_kind  = part_cnt_reg[2] ? PK_CI : PK_CR;
                cmd.mul_part  = part_cnt_reg[1:0];
            end
            ST_C_NEG:
                cmd.c_neg = 1'b1;
            ST_C_ADD:
            begin
                cmd.c_add   = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_Z_MUL:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_part  = part_cnt_reg[1:0];
                unique case (part_cnt_reg[3:2])
                    2'd0:    cmd.mul_kind = PK_SQR;
                    2'd1:    cmd.mul_kind = PK_SQI;
                    default: cmd.mul_kind = PK_ZZ;
                endcase
            end
            ST_CHECK:
            begin
                cmd.check_prep = 1'b1;
                cmd.count_inc  = !stat.escape;
            end
            ST_ROUND:
                cmd.round_step = 1'b1;
            ST_UPD_R:
                cmd.upd_r = 1'b1;
            ST_UPD_I:
                cmd.upd_i = 1'b1;
            ST_UPD_MAG:
            begin
                cmd.upd_mag = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    m_tvalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            part_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            part_cnt_reg <= part_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_C_MUL))
        else $error("accepted beat did not start the c computation");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote an untaken beat");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        part_cnt_reg < PART_CNT_W'(Z_ISSUES))
        else $error("partial product counter ran past last issue");

    a_escape_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && stat.escape) |=> (state_reg == ST_FINISH))
        else $error("escape did not end iteration");
`endif

endmodule
`default_nettype wire

// File: hdl/mandelbrot_escape_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time engine: one pixel coordinate in, one iteration count and pixel index out
// ----------------------------------------------------------------------------
// operation: c is formed first, then z = z^2 + c is iterated with one
//   escape test per pass (iter_count + 1 tests on escape, iter_count at the
//   limit); each pass runs one half-width multiplier over 12 partial products
// throughput: one pixel at a time, a new pixel beat taken only once the last
//   result is loaded
// reset: registers go to their reset values, engine idle, no result pending
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int MAX_TILE_DIM = MAX_TILE_DIM_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // pixel beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,    // col [11:0], row [23:12]
    // result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,    // iter_count [15:0], pixel_index [39:16]
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // register file outputs
    logic signed [COORD_BITS-1:0] origin_real;
    logic signed [COORD_BITS-1:0] origin_imag;
    logic signed [COORD_BITS-1:0] step_real;
    logic signed [COORD_BITS-1:0] step_imag;
    logic [LIMIT_W-1:0]           iter_limit;
    logic [THR_W-1:0]             esc_thr;
    logic [TILE_W_W-1:0]          tile_width;

    // controller to datapath
    dp_cmd_t                      cmd;
    dp_stat_t                     stat;

    // result payload
    logic [COUNT_OUT_W-1:0]       out_count;
    logic [INDEX_W-1:0]           out_index;

    // the user must write registers only while no pixel is in flight; the block does not enforce it
    mbe_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .origin_real (origin_real),
        .origin_imag (origin_imag),
        .step_real   (step_real),
        .step_imag   (step_imag),
        .iter_limit  (iter_limit),
        .esc_thr     (esc_thr),
        .tile_width  (tile_width)
    );

    // sequencer: c setup, then per pass 12 partial products of |zr|^2,
    // |zi|^2 and |zr*zi|, escape test, rounding and z update
    mbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic: exact products, round to nearest with ties up, saturation
    mbe_dp #(
        .COORD_BITS   (COORD_BITS),
        .MAX_TILE_DIM (MAX_TILE_DIM),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .s_col       (s_tdata[COL_W-1:0]),
        .s_row       (s_tdata[COL_W+ROW_W-1:COL_W]),
        .origin_real (origin_real),
        .origin_imag (origin_imag),
        .step_real   (step_real),
        .step_imag   (step_imag),
        .iter_limit  (iter_limit),
        .esc_thr     (esc_thr),
        .tile_width  (tile_width),
        .out_count   (out_count),
        .out_index   (out_index)
    );

    // result beat layout: iteration count in the low bits, pixel index above it
    assign m_tdata = {out_index, out_count};

endmodule
`default_nettype wire
